// ===== design/sfdl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_pkg
// Shared constants, configuration record and control/status types for the
// stereo feedback delay line.
// ----------------------------------------------------------------------------
package sfdl_pkg;

  localparam int MAX_DEPTH   = 65536;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LEN_W      = 17;
  localparam int GAIN_W     = 16;
  localparam int IO_W       = 16;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_LENGTH  = 3'd0,
    CFG_INPUT_GAIN     = 3'd1,
    CFG_FEEDBACK_GAIN  = 3'd2,
    CFG_OUTPUT_GAIN    = 3'd3,
    CFG_TARGET_DELAY   = 3'd4,
    CFG_SMOOTHING_COEF = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]   buffer_length;
    logic [GAIN_W-1:0]  input_gain;
    logic [GAIN_W-1:0]  feedback_gain;
    logic [GAIN_W-1:0]  output_gain;
    logic [DELAY_W-1:0] target_delay;
    logic [DELAY_W-1:0] smoothing_coef;
  } cfg_t;

  // One strobe per datapath step.
  typedef struct packed {
    logic accept;
    logic feedback;
    logic write;
    logic smooth;
    logic offset;
    logic read;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/sfdl_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_ifs
// Valid/ready channel interfaces: sample input, sample output, config write.
// ----------------------------------------------------------------------------
interface sfdl_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sfdl_pkg::IO_W-1:0] left_in;
  logic signed [sfdl_pkg::IO_W-1:0] right_in;
  logic        [sfdl_pkg::IO_W-1:0] mod_value;

  modport source (output valid, output left_in, output right_in, output mod_value,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input mod_value,
                  output ready);
endinterface

interface sfdl_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sfdl_pkg::IO_W-1:0] left_out;
  logic signed [sfdl_pkg::IO_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sfdl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sfdl_pkg::CFG_IDX_W-1:0]      index;
  logic [sfdl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/sfdl_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sfdl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [sfdl_pkg::CFG_IDX_W-1:0]  index,
  input  logic [sfdl_pkg::CFG_DATA_W-1:0] data,
  output sfdl_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_length  <= sfdl_pkg::LEN_W'(65536);
      cfg.input_gain     <= sfdl_pkg::GAIN_W'(32768);
      cfg.feedback_gain  <= '0;
      cfg.output_gain    <= sfdl_pkg::GAIN_W'(32768);
      cfg.target_delay   <= sfdl_pkg::DELAY_W'(32768);
      cfg.smoothing_coef <= sfdl_pkg::DELAY_W'(66);
    end else if (we) begin
      case (sfdl_pkg::cfg_idx_t'(index))
        sfdl_pkg::CFG_BUFFER_LENGTH:  cfg.buffer_length  <= data[sfdl_pkg::LEN_W-1:0];
        sfdl_pkg::CFG_INPUT_GAIN:     cfg.input_gain     <= data[sfdl_pkg::GAIN_W-1:0];
        sfdl_pkg::CFG_FEEDBACK_GAIN:  cfg.feedback_gain  <= data[sfdl_pkg::GAIN_W-1:0];
        sfdl_pkg::CFG_OUTPUT_GAIN:    cfg.output_gain    <= data[sfdl_pkg::GAIN_W-1:0];
        sfdl_pkg::CFG_TARGET_DELAY:   cfg.target_delay   <= data[sfdl_pkg::DELAY_W-1:0];
        sfdl_pkg::CFG_SMOOTHING_COEF: cfg.smoothing_coef <= data[sfdl_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sfdl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_ctrl
// Step sequencer: walks each item one step a cycle, output waits on out_free.
// ----------------------------------------------------------------------------
module sfdl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfdl_pkg::dp_status_t status,
  output sfdl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FB     = 7'b0000010,
    S_WR     = 7'b0000100,
    S_SMOOTH = 7'b0001000,
    S_OFS    = 7'b0010000,
    S_RD     = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FB;
        end
      end
      S_FB: begin
        cmd.feedback = 1'b1;
        state_next   = S_WR;
      end
      S_WR: begin
        cmd.write  = 1'b1;
        state_next = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = S_OFS;
      end
      S_OFS: begin
        cmd.offset = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.read   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the item
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/sfdl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfdl_datapath
// Sample stores, index registers, delay smoothing, gain arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module sfdl_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  sfdl_pkg::dp_cmd_t                cmd,
  output sfdl_pkg::dp_status_t             status,
  input  sfdl_pkg::cfg_t                   cfg,
  input  logic signed [sfdl_pkg::IO_W-1:0] left_in,
  input  logic signed [sfdl_pkg::IO_W-1:0] right_in,
  input  logic        [sfdl_pkg::IO_W-1:0] mod_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [sfdl_pkg::IO_W-1:0] left_out,
  output logic signed [sfdl_pkg::IO_W-1:0] right_out
);

  localparam int SB     = sfdl_pkg::SAMPLE_BITS;
  localparam int AW     = sfdl_pkg::ADDR_W;
  localparam int CW     = sfdl_pkg::CNT_W;
  localparam int GW     = sfdl_pkg::GAIN_W;
  localparam int IW     = sfdl_pkg::IO_W;
  localparam int DW     = sfdl_pkg::DELAY_W;
  localparam int WIDE   = (SB > IW) ? SB : IW;
  localparam int ACC_W  = WIDE + GW + 2;
  localparam int POUT_W = SB + GW + 1;
  localparam int SMP_W  = DW + GW + 2;

  localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1 << 14);
  localparam logic signed [POUT_W-1:0] OUT_HALF = POUT_W'(1 << 14);
  localparam logic signed [SMP_W-1:0]  SMP_HALF = SMP_W'(1 << 15);
  localparam logic signed [ACC_W-1:0]  ST_MAX   = ACC_W'((longint'(1) <<< (SB - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  ST_MIN   = -ST_MAX - ACC_W'(1);
  localparam logic signed [POUT_W-1:0] IO_MAX   = POUT_W'((longint'(1) <<< (IW - 1)) - 1);
  localparam logic signed [POUT_W-1:0] IO_MIN   = -IO_MAX - POUT_W'(1);

  function automatic logic signed [SB-1:0] sat_store(input logic signed [ACC_W-1:0] v);
    if (v > ST_MAX) begin
      return ST_MAX[SB-1:0];
    end else if (v < ST_MIN) begin
      return ST_MIN[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  function automatic logic signed [IW-1:0] sat_io(input logic signed [POUT_W-1:0] v);
    if (v > IO_MAX) begin
      return IO_MAX[IW-1:0];
    end else if (v < IO_MIN) begin
      return IO_MIN[IW-1:0];
    end
    return v[IW-1:0];
  endfunction

  // Stores and their read registers
  logic signed [SB-1:0] mem_l [sfdl_pkg::MAX_DEPTH];
  logic signed [SB-1:0] mem_r [sfdl_pkg::MAX_DEPTH];
  logic signed [SB-1:0] rd_l;
  logic signed [SB-1:0] rd_r;
  logic                 rd_ok;

  // Item and step registers
  logic signed [IW-1:0]      xl;
  logic signed [IW-1:0]      xr;
  logic        [IW-1:0]      mod;
  logic signed [IW+GW:0]     prod_in_l;
  logic signed [IW+GW:0]     prod_in_r;
  logic signed [SB+GW:0]     prod_fb_l;
  logic signed [SB+GW:0]     prod_fb_r;
  logic        [DW-1:0]      tgt;
  logic signed [SMP_W-1:0]   smooth_prod;
  logic        [DW-1:0]      cur_delay;
  logic        [CW-1:0]      offset;
  logic        [AW-1:0]      w_idx;
  logic        [AW-1:0]      r_idx;
  logic        [CW-1:0]      fill;

  // Combinational helpers
  logic        [CW-1:0]      len;
  logic signed [SB-1:0]      fb_l;
  logic signed [SB-1:0]      fb_r;
  logic signed [ACC_W-1:0]   acc_l;
  logic signed [ACC_W-1:0]   acc_r;
  logic        [2*DW-1:0]    tgt_prod;
  logic signed [DW:0]        diff;
  logic signed [SMP_W-1:0]   step;
  logic signed [DW+2:0]      nd;
  logic        [DW-1:0]      nd_clamped;
  logic        [CW+DW-1:0]   ofs_prod;
  logic        [CW:0]        r_calc;
  logic        [AW-1:0]      r_next;
  logic        [CW-1:0]      w_inc;
  logic        [AW-1:0]      w_next;
  logic        [AW-1:0]      rd_addr;
  logic                      rd_en;
  logic signed [POUT_W-1:0]  pout_l;
  logic signed [POUT_W-1:0]  pout_r;

  assign status.out_free = !out_valid || out_ready;

  // Effective length: zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (cfg.buffer_length == '0) begin
      len = CW'(1);
    end else if (32'(cfg.buffer_length) > sfdl_pkg::MAX_DEPTH) begin
      len = CW'(sfdl_pkg::MAX_DEPTH);
    end else begin
      len = CW'(cfg.buffer_length);
    end
  end

  // Write step arithmetic
  assign fb_l  = rd_ok ? rd_l : '0;
  assign fb_r  = rd_ok ? rd_r : '0;
  assign acc_l = (ACC_W'(prod_in_l) + ACC_W'(prod_fb_l) + ACC_HALF) >>> 15;
  assign acc_r = (ACC_W'(prod_in_r) + ACC_W'(prod_fb_r) + ACC_HALF) >>> 15;
  assign w_inc  = CW'(w_idx) + CW'(1);
  assign w_next = (w_inc >= len) ? '0 : w_inc[AW-1:0];

  // Delay target and smoothing
  assign tgt_prod = (2*DW)'(cfg.target_delay) * (2*DW)'(mod);
  assign diff     = $signed({1'b0, tgt}) - $signed({1'b0, cur_delay});
  assign step     = (smooth_prod + SMP_HALF) >>> 16;
  assign nd       = $signed({3'b000, cur_delay}) + (DW+3)'(step);

  always_comb begin
    if (nd < 0) begin
      nd_clamped = '0;
    end else if (nd > $signed((DW+3)'((1 << DW) - 1))) begin
      nd_clamped = '1;
    end else begin
      nd_clamped = nd[DW-1:0];
    end
  end

  // Read position
  assign ofs_prod = (CW+DW)'(len) * (CW+DW)'(cur_delay);

  always_comb begin
    if (offset > CW'(w_idx)) begin
      r_calc = (CW+1)'(w_idx) + (CW+1)'(len) - (CW+1)'(offset);
    end else begin
      r_calc = (CW+1)'(w_idx) - (CW+1)'(offset);
    end
    if (r_calc >= (CW+1)'(len)) begin
      r_next = '0;
    end else begin
      r_next = r_calc[AW-1:0];
    end
  end

  assign rd_addr = cmd.accept ? r_idx : r_next;
  assign rd_en   = cmd.accept || cmd.read;

  // Output gain
  assign pout_l = $signed(rd_ok ? rd_l : '0) * $signed({1'b0, cfg.output_gain});
  assign pout_r = $signed(rd_ok ? rd_r : '0) * $signed({1'b0, cfg.output_gain});

  // Stores; entries at or above the fill count read as zero
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem_l[w_idx] <= sat_store(acc_l);
      mem_r[w_idx] <= sat_store(acc_r);
    end
    if (rd_en) begin
      rd_l  <= mem_l[rd_addr];
      rd_r  <= mem_r[rd_addr];
      rd_ok <= CW'(rd_addr) < fill;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      xl  <= left_in;
      xr  <= right_in;
      mod <= mod_value;
    end
    if (cmd.feedback) begin
      prod_in_l <= xl * $signed({1'b0, cfg.input_gain});
      prod_in_r <= xr * $signed({1'b0, cfg.input_gain});
      prod_fb_l <= fb_l * $signed({1'b0, cfg.feedback_gain});
      prod_fb_r <= fb_r * $signed({1'b0, cfg.feedback_gain});
      tgt       <= tgt_prod[DW+13:14];
    end
    if (cmd.write) begin
      smooth_prod <= SMP_W'(diff) * $signed({{(SMP_W-GW){1'b0}}, cfg.smoothing_coef});
    end
    if (cmd.offset) begin
      offset <= ofs_prod[CW+DW-1:DW];
    end
    if (cmd.load_out) begin
      left_out  <= sat_io((pout_l + OUT_HALF) >>> 15);
      right_out <= sat_io((pout_r + OUT_HALF) >>> 15);
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_idx     <= '0;
      r_idx     <= '0;
      fill      <= '0;
      cur_delay <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write) begin
        w_idx <= w_next;
        if (w_inc > fill) begin
          fill <= w_inc;
        end
      end
      if (cmd.smooth) begin
        cur_delay <= nd_clamped;
      end
      if (cmd.read) begin
        r_idx <= r_next;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/stereo_feedback_delay_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_delay_line
// Stereo circular delay line with feedback and a smoothed, modulated delay.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   din      in   din.valid/din.ready    left_in, right_in, mod_value
//   dout     out  dout.valid/dout.ready  left_out, right_out
//   cfg      in   cfg.valid/cfg.ready    index, data (always ready)
//
// Each item reaches the output register through a chain of dependent steps
// (feedback read, gain products, store write, smoothing product, delay
// update, length product, delayed read and output gain), each ending in a
// register. din is ready only while the sequencer is idle, so a new item is
// taken only once the last one is loaded into the output register. A result
// waiting in the output register does not block the next item, only the
// final step of the item after it. Reset is synchronous. The stores get no
// clearing pass: a fill count marks the written prefix, and any read beyond
// it returns zero, so the block is ready right after reset.
//
module stereo_feedback_delay_line (
  input  logic clk,
  input  logic rst,
  sfdl_in_if.sink    din,
  sfdl_out_if.source dout,
  sfdl_cfg_if.sink   cfg
);

  sfdl_pkg::cfg_t       cfg_regs;
  sfdl_pkg::dp_cmd_t    cmd;
  sfdl_pkg::dp_status_t status;

  // Configuration writes go straight into the register file, so the port never stalls.
  assign cfg.ready = 1'b1;

  sfdl_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg.valid),
    .index (cfg.index),
    .data  (cfg.data),
    .cfg   (cfg_regs)
  );

  // Sequencer: one step of the item per cycle, output step waits on dout.
  sfdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: stores, indexes, delay smoothing and the output register.
  sfdl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg_regs),
    .left_in   (din.left_in),
    .right_in  (din.right_in),
    .mod_value (din.mod_value),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .left_out  (dout.left_out),
    .right_out (dout.right_out)
  );

endmodule
